@@ design/mexp_pkg.sv @@
// shared constants, state encoding and status type for the modular exponentiation block
package mexp_pkg;

	localparam int unsigned OPERAND_BITS_DEF = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} mexp_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mexp_mul_stat_t;

endpackage

@@ design/mexp_mulmod.sv @@
// bit-serial add-and-double modular multiplier, one multiplier bit per cycle
module mexp_mulmod #(
	parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [OPERAND_BITS-1:0]     a,
	input  logic [OPERAND_BITS-1:0]     b,
	input  logic [OPERAND_BITS-1:0]     m,
	output mexp_pkg::mexp_mul_stat_t    stat,
	output logic [OPERAND_BITS-1:0]     product
);
	import mexp_pkg::*;

	localparam int unsigned W  = OPERAND_BITS;
	localparam int unsigned CW = $clog2(W);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  addend_q;
	logic [W-1:0]  mult_q;
	logic [W-1:0]  mod_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    sum;
	logic [W:0]    sum_red;
	logic [W:0]    dbl;
	logic [W:0]    dbl_red;
	logic          last;

	always_comb begin
		sum     = {1'b0, acc_q} + {1'b0, addend_q};
		sum_red = (sum >= {1'b0, mod_q}) ? sum - {1'b0, mod_q} : sum;
		dbl     = {addend_q, 1'b0};
		dbl_red = (dbl >= {1'b0, mod_q}) ? dbl - {1'b0, mod_q} : dbl;
		last    = (cnt_q == CW'(W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			addend_q <= a;
			mult_q   <= b;
			mod_q    <= m;
		end else if (busy_q) begin
			if (mult_q[0]) begin
				acc_q <= sum_red[W-1:0];
			end
			addend_q <= dbl_red[W-1:0];
			mult_q   <= mult_q >> 1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

@@ design/modular_exponentiation.sv @@
// modular exponentiation top level: right-to-left square and multiply on a shared serial unit
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | base_value, exponent_value, modulus
//   rsp     | out       | rsp_valid/rsp_stall  | power_result, div_error
//
// one word at a time: req_stall stays high from acceptance until the sequencer is back in idle
// one square per exponent bit up to its highest set bit, plus a multiply per set bit
// the time per word is set by the single serial modular multiplier, one multiplier bit per cycle
// base reduction runs through the same multiplier as 1 * base
// a zero modulus skips the multiplier, goes straight to ST_DONE and answers with the error flag
// reset clears the sequencer and the result valid; req is taken while a result waits on rsp
module modular_exponentiation #(
	parameter int unsigned OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [OPERAND_BITS-1:0] base_value,
	input  logic [OPERAND_BITS-1:0] exponent_value,
	input  logic [OPERAND_BITS-1:0] modulus,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [OPERAND_BITS-1:0] power_result,
	output logic                    div_error
);
	import mexp_pkg::*;

	localparam int unsigned W = OPERAND_BITS;

	mexp_state_t    state_q;
	mexp_state_t    state_nxt;

	logic [W-1:0]   base_q;
	logic [W-1:0]   exp_q;
	logic [W-1:0]   mod_q;
	logic [W-1:0]   acc_q;
	logic           err_q;
	logic [W-1:0]   power_result_q;
	logic           div_error_q;
	logic           out_valid_q;
	logic           out_free;

	logic           mul_start;
	logic [W-1:0]   mul_a;
	logic [W-1:0]   mul_b;
	logic [W-1:0]   mul_m;
	logic [W-1:0]   mul_product;
	mexp_mul_stat_t mul_stat;

	mexp_mulmod #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.m       (mul_m),
		.stat    (mul_stat),
		.product (mul_product)
	);

	assign out_free = !out_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = (modulus == '0) ? ST_DONE : ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (mul_stat.done) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				priority if (exp_q == '0) begin
					state_nxt = ST_DONE;
				end else if (exp_q[0]) begin
					state_nxt = ST_MUL;
				end else begin
					state_nxt = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mul_stat.done) begin
					state_nxt = ST_SQR;
				end
			end
			ST_SQR: begin
				if (mul_stat.done) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		mul_start = 1'b0;
		mul_a     = base_q;
		mul_b     = base_q;
		mul_m     = mod_q;
		unique case (state_q)
			ST_IDLE: begin
				// base mod m as 1 * base
				if (req_valid && (modulus != '0)) begin
					mul_start = 1'b1;
				end
				mul_a = {{(W-1){1'b0}}, 1'b1};
				mul_b = base_value;
				mul_m = modulus;
			end
			ST_CHECK: begin
				if (exp_q != '0) begin
					mul_start = 1'b1;
					if (exp_q[0]) begin
						mul_a = acc_q;
					end
				end
			end
			ST_MUL: begin
				mul_start = mul_stat.done;
			end
			ST_REDUCE, ST_SQR, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					base_q <= base_value;
					exp_q  <= exponent_value;
					mod_q  <= modulus;
					acc_q  <= (modulus == '0) ? '0 : {{(W-1){1'b0}}, 1'b1};
					err_q  <= (modulus == '0);
				end
			end
			ST_REDUCE: begin
				if (mul_stat.done) begin
					base_q <= mul_product;
				end
			end
			ST_MUL: begin
				if (mul_stat.done) begin
					acc_q <= mul_product;
				end
			end
			ST_SQR: begin
				if (mul_stat.done) begin
					base_q <= mul_product;
					exp_q  <= exp_q >> 1;
				end
			end
			ST_CHECK, ST_DONE: begin
			end
			default: begin
			end
		endcase
		if ((state_q == ST_DONE) && out_free) begin
			power_result_q <= acc_q;
			div_error_q    <= err_q;
		end
	end

	assign rsp_valid    = out_valid_q;
	assign power_result = power_result_q;
	assign div_error    = div_error_q;

`ifndef ASSERT_OFF
	a_done_in_mul_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_REDUCE || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier finished outside a multiply state");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> !mul_stat.busy)
		else $error("multiplier started while busy");

	a_exp_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && $past(state_q) == ST_SQR) |-> (exp_q == ($past(exp_q) >> 1)))
		else $error("exponent not shifted after squaring");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && div_error) |-> (power_result == '0))
		else $error("error word carries a nonzero result");
`endif

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the modular exponentiation block
module tb;
	import mexp_pkg::*;

	localparam int W = OPERAND_BITS_DEF;
	localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
	localparam int RANDOM_WORDS = 272;
	localparam int HOLD_CYCLES = 5000;
	localparam int IDLE_LIMIT = 40000;
	localparam int TAIL_CYCLES = 64;

	typedef struct packed {
		logic [W-1:0] power;
		logic         err;
	} power_word_t;

	class power_scoreboard;
		power_word_t pending_powers[$];
		int mismatches;

		function power_word_t predict_power(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
			power_word_t p;
			logic [63:0] acc;
			logic [63:0] sq;
			logic [63:0] mm;
			logic [W-1:0] ex;
			if (m == '0) begin
				p.power = '0;
				p.err = 1'b1;
				return p;
			end
			mm = 64'(m);
			sq = 64'(b) % mm;
			acc = 64'd1;
			ex = e;
			while (ex != '0) begin
				if (ex[0])
					acc = (acc * sq) % mm;
				sq = (sq * sq) % mm;
				ex = ex >> 1;
			end
			p.power = acc[W-1:0];
			p.err = 1'b0;
			return p;
		endfunction

		function void note_word(logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
			pending_powers.push_back(predict_power(b, e, m));
		endfunction

		function void check_word(logic [W-1:0] power, logic err);
			power_word_t want;
			if (pending_powers.size() == 0) begin
				$error("unexpected word: power_result %0d div_error %0d", power, err);
				mismatches++;
				return;
			end
			want = pending_powers.pop_front();
			if (power !== want.power) begin
				$error("power_result: expected %0d, got %0d", want.power, power);
				mismatches++;
			end
			if (err !== want.err) begin
				$error("div_error: expected %0d, got %0d", want.err, err);
				mismatches++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         req_valid = 1'b0;
	logic         req_stall;
	logic [W-1:0] base_value = '0;
	logic [W-1:0] exponent_value = '0;
	logic [W-1:0] modulus = '0;
	logic         rsp_valid;
	logic         rsp_stall = 1'b0;
	logic [W-1:0] power_result;
	logic         div_error;

	power_scoreboard sb = new();
	int rsp_words = 0;
	int idle_cycles = 0;

	modular_exponentiation #(.OPERAND_BITS(W)) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.modulus        (modulus),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.power_result   (power_result),
		.div_error      (div_error)
	);

	always #6 clk = ~clk;

	task automatic send_word(input logic [W-1:0] b, input logic [W-1:0] e,
		input logic [W-1:0] m);
		req_valid <= 1'b1;
		base_value <= b;
		exponent_value <= e;
		modulus <= m;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_word(b, e, m);
	endtask

	task automatic idle_gap(input int n);
		req_valid <= 1'b0;
		base_value <= W'($urandom);
		exponent_value <= W'($urandom);
		modulus <= W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [W-1:0] pick_base();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return ALL_ONES;
		else if (r < 35)
			return W'($urandom_range(1, 300));
		return W'($urandom);
	endfunction

	function automatic logic [W-1:0] pick_exponent();
		int r;
		int bits;
		r = $urandom_range(0, 99);
		if (r < 10)
			return W'($urandom);
		bits = $urandom_range(0, 10);
		return W'($urandom) & ((W'(1) << bits) - W'(1));
	endfunction

	function automatic logic [W-1:0] pick_modulus();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 10)
			return W'(1);
		else if (r < 30)
			return W'($urandom_range(2, 255));
		return W'($urandom);
	endfunction

	// stimulus and end of run
	initial begin
		int sent;
		int burst;
		int r;
		sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero modulus
		send_word('0, '0, '0);
		send_word(ALL_ONES, ALL_ONES, '0);
		// zero exponent, unit modulus included
		send_word(W'(5), '0, W'(1));
		send_word('0, '0, W'(7));
		send_word(ALL_ONES, '0, ALL_ONES);
		// unit modulus with nonzero exponent, then assorted edge and sample operands
		send_word(W'(7), W'(5), W'(1));
		send_word(ALL_ONES, ALL_ONES, W'(1));
		send_word('0, W'(5), W'(13));
		send_word(ALL_ONES, W'(1), ALL_ONES);
		send_word(ALL_ONES - W'(1), W'(2), ALL_ONES);
		send_word(W'(2), W'(30), ALL_ONES);
		send_word(ALL_ONES, ALL_ONES, ALL_ONES - W'(1));
		send_word(W'(3), ALL_ONES, W'(2147483629));
		send_word(W'(123456789), W'(987654321), W'(1000000007));
		send_word(W'(2), W'(10), W'(1000));
		send_word(ALL_ONES, ALL_ONES, W'(2));
		send_word(W'(1), ALL_ONES, ALL_ONES);
		send_word(W'(32'h4000_0000), W'(3), W'(32'h7fff_fffe));
		send_word(W'(4), W'(13), W'(497));
		send_word(W'(65537), W'(32'h5555_5555), W'(32'h2aaa_aaab));

		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
				send_word(pick_base(), pick_exponent(), pick_modulus());
				sent++;
			end
			r = $urandom_range(0, 99);
			if (r >= 20 && r < 90)
				idle_gap($urandom_range(1, 40));
			else if (r >= 90)
				idle_gap($urandom_range(100, 900));
		end
		req_valid <= 1'b0;

		while (sb.pending_powers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_powers.size() == 0)
			$display("modular_exponentiation regression: pass");
		else
			$display("modular_exponentiation regression: fail");
		$finish;
	end

	// receiver stall pattern, with one long hold once results flow
	initial begin
		bit held;
		int n;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && rsp_words >= 40) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = $urandom_range(1, 300);
				case ($urandom_range(0, 2))
					0: begin
						rsp_stall <= 1'b0;
						repeat (n) @(posedge clk);
					end
					1: begin
						rsp_stall <= 1'b1;
						repeat ($urandom_range(1, 40)) @(posedge clk);
					end
					default: begin
						repeat (n) begin
							rsp_stall <= 1'($urandom_range(0, 1));
							@(posedge clk);
						end
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			sb.check_word(power_result, div_error);
			rsp_words++;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("modular_exponentiation regression: fail");
			$finish;
		end
	end

endmodule
